### src/midpoint_hyperbola_rasterizer_core_assert.svh
// Assertion helpers for the hyperbola rasterizer.
// Both expect clk and rst_n to be visible where they are used.
`ifndef MIDPOINT_HYPERBOLA_RASTERIZER_CORE_ASSERT_SVH
`define MIDPOINT_HYPERBOLA_RASTERIZER_CORE_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define MHR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define MHR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mhr_pkg.sv
`default_nettype none

package mhr_pkg;

    localparam int AXIS_W    = 10;
    localparam int SQ_W      = 20;
    localparam int DEC_W     = 48;
    localparam int REG_W     = 11;
    localparam int OUT_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 56;
    localparam int M_PAD_W   = M_TDATA_W - 4 * OUT_W;

    localparam logic [REG_W-1:0] CENTER_X_RST = 11'd300;
    localparam logic [REG_W-1:0] CENTER_Y_RST = 11'd240;
    localparam logic [REG_W-1:0] Y_LIMIT_RST  = 11'd220;
    localparam logic [REG_W-1:0] X_LIMIT_RST  = 11'd2047;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT  = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_R1,
        PH_R2
    } phase_t;

    typedef enum logic [4:0] {
        SQ_IDLE,
        SQ_S0, SQ_S1, SQ_S2, SQ_S3, SQ_S4,
        SQ_R1_0, SQ_R1_1, SQ_R1_2, SQ_R1_3, SQ_R1_4, SQ_R1_5, SQ_R1_6,
        SQ_E_0, SQ_E_1, SQ_E_2, SQ_E_3, SQ_E_4, SQ_E_5,
        SQ_R2_0, SQ_R2_1, SQ_R2_2
    } seq_state_t;

    typedef enum logic [2:0] {
        A_A, A_B, A_ASQ, A_BSQ, A_XP1, A_Y2P1
    } a_sel_t;

    typedef enum logic [3:0] {
        B_A, B_B, B_4AP1, B_XP1, B_Y2P3, B_Y2P1,
        B_X, B_Y, B_YP1, B_X2P3, B_P, B_BSQ
    } b_sel_t;

    typedef enum logic [1:0] {
        BASE_ACC, BASE_ZERO, BASE_DEC
    } base_sel_t;

    typedef enum logic [2:0] {
        ADD_NONE, ADD_POS, ADD_NEG, ADD_POS_IF_NEG, ADD_NEG_IF_UP
    } add_mode_t;

    typedef struct packed {
        a_sel_t    a_sel;
        b_sel_t    b_sel;
        base_sel_t base_sel;
        add_mode_t add_mode;
        logic [1:0] shift;
        logic      commit_d;
        logic      wr_asq;
        logic      wr_bsq;
        logic      step_r1;
        logic      step_r2;
    } seq_ctrl_t;

endpackage

`default_nettype wire

### src/midpoint_hyperbola_rasterizer_core.sv
// Each input beat produces one result beat, registered at acceptance.
// After acceptance the block is busy: setup states for a start, region-1 states
// (plus entry states on a crossing) or region-2 states for a step, none when done.
// Busy time is set by one shared 20x26-bit multiplier into a 48-bit accumulator.
// The next beat is taken once the sequencer is idle and the output register is free.
// rst_n (asynchronous, active low) idles the curve and loads default register values.
`default_nettype none

`include "midpoint_hyperbola_rasterizer_core_assert.svh"

module midpoint_hyperbola_rasterizer_core #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // s_axis_tdata: semi_axis_a [9:0], semi_axis_b [19:10], zero pad above
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [mhr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // s_axis_tuser: op
    input  wire logic                          s_axis_tuser,
    // m_axis_tdata: x_right [12:0], x_left [25:13], y_above [38:26],
    // y_below [51:39], zero pad above
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [mhr_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // m_axis_tuser: point_valid
    output logic                               m_axis_tuser,
    // m_axis_tlast: done_res
    output logic                               m_axis_tlast,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mhr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mhr_pkg::REG_W-1:0]     cfg_data
);

    import mhr_pkg::*;

    localparam int SQB_W  = (2 * COORD_BITS + 2 > SQ_W) ? 2 * COORD_BITS + 2 : SQ_W;
    localparam int PROD_W = SQ_W + SQB_W;
    localparam int CMP_W  = (COORD_BITS > REG_W) ? COORD_BITS : REG_W;

    // Configuration registers
    logic [REG_W-1:0] center_x_reg, center_y_reg, y_limit_reg, x_limit_reg;

    // Control state
    seq_state_t seq_state_reg, seq_state_next;
    phase_t     phase_reg;
    logic       m_valid_reg;

    // Datapath state
    logic [AXIS_W-1:0]     a_reg, b_reg;
    logic [SQ_W-1:0]       asq_reg, bsq_reg;
    logic [COORD_BITS-1:0] cur_x_reg, cur_y_reg;
    logic [DEC_W-1:0]      decision_reg, acc_reg, p_reg;
    logic [OUT_W-1:0]      x_right_reg, x_left_reg, y_above_reg, y_below_reg;
    logic                  point_valid_reg, done_res_reg;

    seq_ctrl_t ctrl;

    logic s_accept, is_start, curve_active, limit_hit;
    logic dec_neg, dec_up, acc_pos;

    logic [COORD_BITS:0]   x_p1, y_p1, y2_p1;
    logic [COORD_BITS+1:0] x2_p3, y2_p3;
    logic [AXIS_W+1:0]     a4_p1;

    logic [SQ_W-1:0]         mul_a;
    logic [SQB_W-1:0]        mul_b;
    logic [PROD_W-1:0]       prod;
    logic [PROD_W+DEC_W-1:0] prod_pad;
    logic [DEC_W-1:0]        term_sh, term_eff, acc_base, acc_sum;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (seq_state_reg == SQ_IDLE) && (!m_valid_reg || m_axis_tready);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign is_start      = (s_axis_tuser == OP_START);
    assign curve_active  = (phase_reg == PH_R1) || (phase_reg == PH_R2);
    assign limit_hit     = (CMP_W'(cur_y_reg) >= CMP_W'(y_limit_reg))
                        || (CMP_W'(cur_x_reg) >= CMP_W'(x_limit_reg));

    assign dec_neg = decision_reg[DEC_W-1];
    assign dec_up  = !decision_reg[DEC_W-1] && (decision_reg != '0);
    assign acc_pos = !acc_reg[DEC_W-1] && (acc_reg != '0);

    assign x_p1  = {1'b0, cur_x_reg} + (COORD_BITS+1)'(1);
    assign y_p1  = {1'b0, cur_y_reg} + (COORD_BITS+1)'(1);
    assign y2_p1 = {cur_y_reg, 1'b1};
    assign y2_p3 = {1'b0, cur_y_reg, 1'b1} + (COORD_BITS+2)'(2);
    assign x2_p3 = {1'b0, cur_x_reg, 1'b1} + (COORD_BITS+2)'(2);
    assign a4_p1 = {a_reg, 2'b01};

    // Sequencer: next state
    always_comb
    begin
        seq_state_next = seq_state_reg;
        unique case (seq_state_reg)
            SQ_IDLE:
            begin
                if (s_accept)
                begin
                    if (is_start)
                    begin
                        seq_state_next = SQ_S0;
                    end
                    else if (curve_active && !limit_hit)
                    begin
                        seq_state_next = (phase_reg == PH_R1) ? SQ_R1_0 : SQ_R2_0;
                    end
                end
            end
            SQ_S0:   seq_state_next = SQ_S1;
            SQ_S1:   seq_state_next = SQ_S2;
            SQ_S2:   seq_state_next = SQ_S3;
            SQ_S3:   seq_state_next = SQ_S4;
            SQ_S4:   seq_state_next = SQ_IDLE;
            SQ_R1_0: seq_state_next = SQ_R1_1;
            SQ_R1_1: seq_state_next = SQ_R1_2;
            SQ_R1_2: seq_state_next = SQ_R1_3;
            SQ_R1_3: seq_state_next = SQ_R1_4;
            SQ_R1_4: seq_state_next = SQ_R1_5;
            SQ_R1_5: seq_state_next = SQ_R1_6;
            SQ_R1_6: seq_state_next = acc_pos ? SQ_E_0 : SQ_IDLE;
            SQ_E_0:  seq_state_next = SQ_E_1;
            SQ_E_1:  seq_state_next = SQ_E_2;
            SQ_E_2:  seq_state_next = SQ_E_3;
            SQ_E_3:  seq_state_next = SQ_E_4;
            SQ_E_4:  seq_state_next = SQ_E_5;
            SQ_E_5:  seq_state_next = SQ_IDLE;
            SQ_R2_0: seq_state_next = SQ_R2_1;
            SQ_R2_1: seq_state_next = SQ_R2_2;
            SQ_R2_2: seq_state_next = SQ_IDLE;
            default: seq_state_next = SQ_IDLE;
        endcase
    end

    // Sequencer: control word. A product issued in one state is accumulated
    // in the following state.
    always_comb
    begin
        ctrl          = '0;
        ctrl.a_sel    = A_A;
        ctrl.b_sel    = B_A;
        ctrl.base_sel = BASE_ACC;
        ctrl.add_mode = ADD_NONE;
        unique case (seq_state_reg)
            SQ_S0:
            begin
                ctrl.a_sel = A_A;
                ctrl.b_sel = B_A;
            end
            SQ_S1:
            begin
                ctrl.a_sel    = A_B;
                ctrl.b_sel    = B_B;
                ctrl.base_sel = BASE_ZERO;
                ctrl.add_mode = ADD_NEG;
                ctrl.shift    = 2'd2;
                ctrl.wr_asq   = 1'b1;
            end
            SQ_S2:
            begin
                ctrl.wr_bsq = 1'b1;
            end
            SQ_S3:
            begin
                ctrl.a_sel = A_BSQ;
                ctrl.b_sel = B_4AP1;
            end
            SQ_S4:
            begin
                ctrl.add_mode = ADD_POS;
                ctrl.commit_d = 1'b1;
            end
            SQ_R1_0:
            begin
                ctrl.a_sel    = A_BSQ;
                ctrl.b_sel    = B_XP1;
                ctrl.base_sel = BASE_DEC;
            end
            SQ_R1_1:
            begin
                ctrl.a_sel    = A_ASQ;
                ctrl.b_sel    = B_Y2P3;
                ctrl.add_mode = ADD_POS_IF_NEG;
                ctrl.shift    = 2'd3;
            end
            SQ_R1_2:
            begin
                ctrl.add_mode = ADD_NEG;
                ctrl.shift    = 2'd2;
                ctrl.commit_d = 1'b1;
                ctrl.step_r1  = 1'b1;
            end
            SQ_R1_3:
            begin
                ctrl.a_sel = A_ASQ;
                ctrl.b_sel = B_Y;
            end
            SQ_R1_4:
            begin
                ctrl.a_sel    = A_BSQ;
                ctrl.b_sel    = B_X;
                ctrl.base_sel = BASE_ZERO;
                ctrl.add_mode = ADD_POS;
            end
            SQ_R1_5:
            begin
                ctrl.add_mode = ADD_NEG;
            end
            SQ_E_0:
            begin
                ctrl.a_sel    = A_XP1;
                ctrl.b_sel    = B_XP1;
                ctrl.base_sel = BASE_ZERO;
            end
            SQ_E_1:
            begin
                ctrl.a_sel = A_BSQ;
                ctrl.b_sel = B_P;
            end
            SQ_E_2:
            begin
                ctrl.a_sel    = A_Y2P1;
                ctrl.b_sel    = B_Y2P1;
                ctrl.add_mode = ADD_POS;
                ctrl.shift    = 2'd2;
            end
            SQ_E_3:
            begin
                ctrl.a_sel = A_ASQ;
                ctrl.b_sel = B_P;
            end
            SQ_E_4:
            begin
                ctrl.a_sel    = A_ASQ;
                ctrl.b_sel    = B_BSQ;
                ctrl.add_mode = ADD_NEG;
            end
            SQ_E_5:
            begin
                ctrl.add_mode = ADD_NEG;
                ctrl.shift    = 2'd2;
                ctrl.commit_d = 1'b1;
            end
            SQ_R2_0:
            begin
                ctrl.a_sel    = A_BSQ;
                ctrl.b_sel    = B_X2P3;
                ctrl.base_sel = BASE_DEC;
            end
            SQ_R2_1:
            begin
                ctrl.a_sel    = A_ASQ;
                ctrl.b_sel    = B_YP1;
                ctrl.add_mode = ADD_POS;
                ctrl.shift    = 2'd2;
            end
            SQ_R2_2:
            begin
                ctrl.add_mode = ADD_NEG_IF_UP;
                ctrl.shift    = 2'd3;
                ctrl.commit_d = 1'b1;
                ctrl.step_r2  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Shared multiplier operands
    always_comb
    begin
        unique case (ctrl.a_sel)
            A_A:     mul_a = SQ_W'(a_reg);
            A_B:     mul_a = SQ_W'(b_reg);
            A_ASQ:   mul_a = asq_reg;
            A_BSQ:   mul_a = bsq_reg;
            A_XP1:   mul_a = SQ_W'(x_p1);
            A_Y2P1:  mul_a = SQ_W'(y2_p1);
            default: mul_a = '0;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.b_sel)
            B_A:     mul_b = SQB_W'(a_reg);
            B_B:     mul_b = SQB_W'(b_reg);
            B_4AP1:  mul_b = SQB_W'(a4_p1);
            B_XP1:   mul_b = SQB_W'(x_p1);
            B_Y2P3:  mul_b = SQB_W'(y2_p3);
            B_Y2P1:  mul_b = SQB_W'(y2_p1);
            B_X:     mul_b = SQB_W'(cur_x_reg);
            B_Y:     mul_b = SQB_W'(cur_y_reg);
            B_YP1:   mul_b = SQB_W'(y_p1);
            B_X2P3:  mul_b = SQB_W'(x2_p3);
            B_P:     mul_b = p_reg[SQB_W-1:0];
            B_BSQ:   mul_b = SQB_W'(bsq_reg);
            default: mul_b = '0;
        endcase
    end

    assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_pad = {{DEC_W{1'b0}}, prod};

    // Accumulator, modulo 2^48
    assign term_sh = p_reg << ctrl.shift;

    always_comb
    begin
        unique case (ctrl.add_mode)
            ADD_NONE:       term_eff = '0;
            ADD_POS:        term_eff = term_sh;
            ADD_NEG:        term_eff = -term_sh;
            ADD_POS_IF_NEG: term_eff = dec_neg ? term_sh : '0;
            ADD_NEG_IF_UP:  term_eff = dec_up ? -term_sh : '0;
            default:        term_eff = '0;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.base_sel)
            BASE_ACC:  acc_base = acc_reg;
            BASE_ZERO: acc_base = '0;
            BASE_DEC:  acc_base = decision_reg;
            default:   acc_base = '0;
        endcase
    end

    assign acc_sum = acc_base + term_eff;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_state_reg <= SQ_IDLE;
            phase_reg     <= PH_IDLE;
            m_valid_reg   <= 1'b0;
            center_x_reg  <= CENTER_X_RST;
            center_y_reg  <= CENTER_Y_RST;
            y_limit_reg   <= Y_LIMIT_RST;
            x_limit_reg   <= X_LIMIT_RST;
        end
        else
        begin
            seq_state_reg <= seq_state_next;

            if (s_accept)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            if (s_accept && is_start)
            begin
                phase_reg <= PH_R1;
            end
            else if (s_accept && curve_active && limit_hit)
            begin
                phase_reg <= PH_IDLE;
            end
            else if ((seq_state_reg == SQ_R1_6) && acc_pos)
            begin
                phase_reg <= PH_R2;
            end

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_CENTER_X: center_x_reg <= cfg_data;
                    CFG_CENTER_Y: center_y_reg <= cfg_data;
                    CFG_Y_LIMIT:  y_limit_reg  <= cfg_data;
                    CFG_X_LIMIT:  x_limit_reg  <= cfg_data;
                    default:      center_x_reg <= center_x_reg;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        p_reg   <= prod_pad[DEC_W-1:0];
        acc_reg <= acc_sum;

        if (ctrl.commit_d)
        begin
            decision_reg <= acc_sum;
        end
        if (ctrl.wr_asq)
        begin
            asq_reg <= p_reg[SQ_W-1:0];
        end
        if (ctrl.wr_bsq)
        begin
            bsq_reg <= p_reg[SQ_W-1:0];
        end

        if (s_accept && is_start)
        begin
            a_reg     <= s_axis_tdata[AXIS_W-1:0];
            b_reg     <= s_axis_tdata[2*AXIS_W-1:AXIS_W];
            cur_x_reg <= COORD_BITS'(s_axis_tdata[AXIS_W-1:0]);
            cur_y_reg <= '0;
        end
        else if (ctrl.step_r1)
        begin
            if (dec_neg)
            begin
                cur_x_reg <= cur_x_reg + COORD_BITS'(1);
            end
            cur_y_reg <= cur_y_reg + COORD_BITS'(1);
        end
        else if (ctrl.step_r2)
        begin
            if (dec_up)
            begin
                cur_y_reg <= cur_y_reg + COORD_BITS'(1);
            end
            cur_x_reg <= cur_x_reg + COORD_BITS'(1);
        end

        if (s_accept)
        begin
            if (is_start || !curve_active)
            begin
                x_right_reg     <= '0;
                x_left_reg      <= '0;
                y_above_reg     <= '0;
                y_below_reg     <= '0;
                point_valid_reg <= 1'b0;
                done_res_reg    <= 1'b0;
            end
            else
            begin
                x_right_reg     <= OUT_W'(center_x_reg) + OUT_W'(cur_x_reg);
                x_left_reg      <= OUT_W'(center_x_reg) - OUT_W'(cur_x_reg);
                y_above_reg     <= OUT_W'(center_y_reg) - OUT_W'(cur_y_reg);
                y_below_reg     <= OUT_W'(center_y_reg) + OUT_W'(cur_y_reg);
                point_valid_reg <= 1'b1;
                done_res_reg    <= limit_hit;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, y_below_reg, y_above_reg, x_left_reg, x_right_reg};
    assign m_axis_tuser  = point_valid_reg;
    assign m_axis_tlast  = done_res_reg;

    `MHR_ASSERT_NOW(a_busy_blocks_input, seq_state_reg != SQ_IDLE, !s_axis_tready,
        "input taken while sequencer busy")
    `MHR_ASSERT_NEXT(a_start_enters_setup, s_accept && is_start,
        seq_state_reg == SQ_S0 && phase_reg == PH_R1, "start did not enter setup")
    `MHR_ASSERT_NEXT(a_last_point_idles, s_accept && !is_start && curve_active && limit_hit,
        phase_reg == PH_IDLE && seq_state_reg == SQ_IDLE && m_axis_tlast,
        "last point did not end the curve")
    `MHR_ASSERT_NOW(a_r2_states_in_r2,
        seq_state_reg == SQ_R2_0 || seq_state_reg == SQ_R2_1 || seq_state_reg == SQ_R2_2
        || seq_state_reg == SQ_E_0 || seq_state_reg == SQ_E_5,
        phase_reg == PH_R2, "region-2 work outside region 2")
    `MHR_ASSERT_NOW(a_done_has_point, m_axis_tvalid && m_axis_tlast, m_axis_tuser,
        "done flagged without a point")

endmodule

`default_nettype wire

### sim/midpoint_hyperbola_rasterizer_core_checker.sv
module midpoint_hyperbola_rasterizer_core_checker #(
    parameter int COORD_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [mhr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [mhr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                          m_axis_tuser,
    input  logic                          m_axis_tlast,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [mhr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mhr_pkg::REG_W-1:0]     cfg_data,
    output int                            errors,
    output int                            pending,
    output int                            points,
    output int                            curve_ends,
    output int                            region2_entries
);
    import mhr_pkg::*;

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [OUT_W-1:0] x_right;
        logic [OUT_W-1:0] x_left;
        logic [OUT_W-1:0] y_above;
        logic [OUT_W-1:0] y_below;
        logic             point_valid;
        logic             done_res;
    } pixel_t;

    logic [REG_W-1:0]      center_x;
    logic [REG_W-1:0]      center_y;
    logic [REG_W-1:0]      y_limit;
    logic [REG_W-1:0]      x_limit;
    phase_t                curve_phase;
    logic [COORD_BITS-1:0] off_x;
    logic [COORD_BITS-1:0] off_y;
    logic [DEC_W-1:0]      decision;
    logic [SQ_W-1:0]       a_sq;
    logic [SQ_W-1:0]       b_sq;
    pixel_t                expected_pixels[$];

    initial begin
        errors = 0;
        pending = 0;
        points = 0;
        curve_ends = 0;
        region2_entries = 0;
    end

    // A step emits the curve's point, then moves it one pixel along or ends it.
    task automatic rasterize(input logic op, input logic [AXIS_W-1:0] a,
                             input logic [AXIS_W-1:0] b, output pixel_t pix);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] d;
        logic [63:0] asq64;
        logic [63:0] bsq64;
        logic [63:0] coord_mask;
        logic        up;
        pix = '0;
        coord_mask = (64'd1 << COORD_BITS) - 64'd1;
        if (op == OP_START) begin
            asq64 = 64'(a) * 64'(a);
            bsq64 = 64'(b) * 64'(b);
            a_sq = asq64[SQ_W-1:0];
            b_sq = bsq64[SQ_W-1:0];
            off_x = COORD_BITS'(a);
            off_y = '0;
            d = bsq64 * (4 * 64'(a) + 1) - 4 * asq64;
            decision = d[DEC_W-1:0];
            curve_phase = PH_R1;
        end else if (curve_phase == PH_R1 || curve_phase == PH_R2) begin
            pix.x_right = center_x + off_x;
            pix.x_left = center_x - off_x;
            pix.y_above = center_y - off_y;
            pix.y_below = center_y + off_y;
            pix.point_valid = 1'b1;
            if (off_y >= y_limit || off_x >= x_limit) begin
                pix.done_res = 1'b1;
                curve_phase = PH_IDLE;
                curve_ends++;
            end else begin
                x = 64'(off_x);
                y = 64'(off_y);
                d = 64'(decision);
                asq64 = 64'(a_sq);
                bsq64 = 64'(b_sq);
                if (curve_phase == PH_R1) begin
                    if (d[DEC_W-1]) begin
                        d = d + 8 * bsq64 * (x + 1) - 4 * asq64 * (2 * y + 3);
                        x = (x + 1) & coord_mask;
                    end else begin
                        d = d - 4 * asq64 * (2 * y + 3);
                    end
                    y = (y + 1) & coord_mask;
                    // Slope has dropped below one: restart the decision at the
                    // region-2 midpoint.
                    if (asq64 * y > bsq64 * x) begin
                        curve_phase = PH_R2;
                        region2_entries++;
                        d = 4 * bsq64 * (x + 1) * (x + 1)
                            - asq64 * (2 * y + 1) * (2 * y + 1)
                            - 4 * asq64 * bsq64;
                    end
                end else begin
                    up = !d[DEC_W-1] && (d[DEC_W-1:0] != '0);
                    d = d + 4 * bsq64 * (2 * x + 3);
                    if (up) begin
                        d = d - 8 * asq64 * (y + 1);
                        y = (y + 1) & coord_mask;
                    end
                    x = (x + 1) & coord_mask;
                end
                off_x = x[COORD_BITS-1:0];
                off_y = y[COORD_BITS-1:0];
                decision = d[DEC_W-1:0];
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [OUT_W-1:0] want,
                                 input logic [OUT_W-1:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d (0x%h), got %0d (0x%h)",
                         $time, name, want, want, got, got);
        end
    endtask

    always @(posedge clk) begin : watch
        pixel_t want;
        pixel_t pix;
        if (!rst_n) begin
            center_x = CENTER_X_RST;
            center_y = CENTER_Y_RST;
            y_limit = Y_LIMIT_RST;
            x_limit = X_LIMIT_RST;
            curve_phase = PH_IDLE;
            off_x = '0;
            off_y = '0;
            decision = '0;
            a_sq = '0;
            b_sq = '0;
            expected_pixels.delete();
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CENTER_X: center_x = cfg_data;
                    CFG_CENTER_Y: center_y = cfg_data;
                    CFG_Y_LIMIT:  y_limit = cfg_data;
                    CFG_X_LIMIT:  x_limit = cfg_data;
                    default: ;
                endcase
            end
            // Results leave before the new input beat is queued, so an
            // unexpected result beat cannot hide behind a fresh expectation.
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pixels.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result beat with nothing expected, tdata 0x%h",
                                 $time, m_axis_tdata);
                end else begin
                    want = expected_pixels.pop_front();
                    compare_field("x_right", want.x_right, m_axis_tdata[OUT_W-1:0]);
                    compare_field("x_left", want.x_left, m_axis_tdata[2*OUT_W-1:OUT_W]);
                    compare_field("y_above", want.y_above,
                                  m_axis_tdata[3*OUT_W-1:2*OUT_W]);
                    compare_field("y_below", want.y_below,
                                  m_axis_tdata[4*OUT_W-1:3*OUT_W]);
                    compare_field("point_valid", OUT_W'(want.point_valid),
                                  OUT_W'(m_axis_tuser));
                    compare_field("done_res", OUT_W'(want.done_res), OUT_W'(m_axis_tlast));
                    if (want.point_valid)
                        points++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                rasterize(s_axis_tuser, s_axis_tdata[AXIS_W-1:0],
                          s_axis_tdata[2*AXIS_W-1:AXIS_W], pix);
                expected_pixels.push_back(pix);
            end
            pending <= expected_pixels.size();
        end
    end

endmodule

### sim/midpoint_hyperbola_rasterizer_core_tb.sv
module midpoint_hyperbola_rasterizer_core_tb;
    import mhr_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 10;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = 24;
    localparam int RANDOM_ITEMS = 850;
    localparam int REG_MAX      = (1 << REG_W) - 1;
    localparam int AXIS_MAX     = (1 << AXIS_W) - 1;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER [4] =
        '{CFG_CENTER_X, CFG_CENTER_Y, CFG_Y_LIMIT, CFG_X_LIMIT};

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PULSED
    } rx_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tuser = OP_START;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_CENTER_X;
    logic [REG_W-1:0]       cfg_data = '0;

    int errors;
    int pending;
    int points;
    int curve_ends;
    int region2_entries;

    int       cycles = 0;
    int       beats = 0;
    int       settings = 0;
    int       burst_left = 0;
    rx_mode_t rx_mode = RX_FREE;
    int       rx_left = 0;

    logic [REG_W-1:0] next_regs [4];
    logic [REG_W-1:0] live_regs [4];

    midpoint_hyperbola_rasterizer_core dut (.*);

    midpoint_hyperbola_rasterizer_core_checker checker_i (.*);

    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The receiver changes its stall behavior whenever its mode count runs out.
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 96);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE:  m_axis_tready <= 1'b1;
            RX_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:  m_axis_tready <= rx_left[3];
        endcase
    end

    task automatic send_beat(input logic op, input logic [AXIS_W-1:0] a,
                             input logic [AXIS_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = 1;
                2: gap = $urandom_range(2, 5);
                default: gap = $urandom_range(6, 12);
            endcase
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= S_TDATA_W'({b, a});
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        beats++;
    endtask

    task automatic draw_curve(input int a, input int b, input int steps);
        send_beat(OP_START, AXIS_W'(a), AXIS_W'(b));
        repeat (steps) send_beat(OP_STEP, AXIS_W'($urandom), AXIS_W'($urandom));
    endtask

    // Holds the sender until every result is out and the core has gone quiet.
    task automatic sender_pause();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic program_regs(input logic [3:0] which);
        for (int k = 0; k < 4; k++) begin
            if (which[k]) begin
                cfg_valid <= 1'b1;
                cfg_index <= REG_ORDER[k];
                cfg_data <= next_regs[REG_ORDER[k]];
                @(posedge clk);
                while (!cfg_ready) @(posedge clk);
                live_regs[REG_ORDER[k]] = next_regs[REG_ORDER[k]];
            end
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    function automatic logic [REG_W-1:0] pick_center();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return REG_W'(REG_MAX);
            default: return REG_W'($urandom);
        endcase
    endfunction

    initial begin
        int   random_start;
        int   phase_end;
        int   a;
        int   b;
        int   steps;
        int   lo;
        int   hi;
        int   lim;
        logic first_phase;
        logic x_bound;

        live_regs[CFG_CENTER_X] = CENTER_X_RST;
        live_regs[CFG_CENTER_Y] = CENTER_Y_RST;
        live_regs[CFG_Y_LIMIT] = Y_LIMIT_RST;
        live_regs[CFG_X_LIMIT] = X_LIMIT_RST;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, on the reset register values first.
        send_beat(OP_STEP, '0, '0);
        draw_curve(AXIS_MAX, AXIS_MAX, 3);
        draw_curve(0, 512, 2);
        draw_curve(341, 0, 3);
        draw_curve(1, 1, 4);

        // Center in a corner, curve ends one row off the axis.
        sender_pause();
        next_regs[CFG_CENTER_X] = '0;
        next_regs[CFG_CENTER_Y] = REG_W'(REG_MAX);
        next_regs[CFG_Y_LIMIT] = REG_W'(1);
        next_regs[CFG_X_LIMIT] = REG_W'(REG_MAX);
        program_regs(4'b1111);
        draw_curve(3, 2, 3);

        // Vertex already past the x limit.
        sender_pause();
        next_regs[CFG_CENTER_X] = REG_W'(REG_MAX);
        next_regs[CFG_CENTER_Y] = '0;
        next_regs[CFG_Y_LIMIT] = REG_W'(REG_MAX);
        next_regs[CFG_X_LIMIT] = REG_W'(1);
        program_regs(4'b1111);
        draw_curve(5, 5, 2);

        random_start = beats;
        first_phase = 1'b1;
        while (beats - random_start < RANDOM_ITEMS) begin
            sender_pause();
            next_regs[CFG_CENTER_X] = pick_center();
            next_regs[CFG_CENTER_Y] = pick_center();
            x_bound = ($urandom_range(0, 3) == 0);
            if (x_bound) begin
                next_regs[CFG_Y_LIMIT] = REG_W'(REG_MAX);
                next_regs[CFG_X_LIMIT] = REG_W'($urandom_range(1, AXIS_MAX + 40));
            end else begin
                next_regs[CFG_Y_LIMIT] = ($urandom_range(0, 5) == 0) ?
                                         REG_W'(1) : REG_W'($urandom_range(2, 24));
                next_regs[CFG_X_LIMIT] = ($urandom_range(0, 2) == 0) ?
                                         REG_W'($urandom_range(1, REG_MAX)) :
                                         REG_W'(REG_MAX);
            end
            // Both limits are always rewritten; the center only sometimes.
            program_regs(first_phase ? 4'b1111 : {2'b11, 2'($urandom)});
            first_phase = 1'b0;

            phase_end = beats + $urandom_range(30, 90);
            while (beats < phase_end) begin
                if ($urandom_range(0, 15) == 0) begin
                    send_beat(1'($urandom), AXIS_W'($urandom), AXIS_W'($urandom));
                end else begin
                    if (x_bound) begin
                        // A flat curve with its vertex near the x limit.
                        lim = live_regs[CFG_X_LIMIT];
                        lo = (lim > 40) ? lim - 40 : 0;
                        hi = (lim + 2 > AXIS_MAX) ? AXIS_MAX : lim + 2;
                        if (lo > hi)
                            lo = hi;
                        a = $urandom_range(lo, hi);
                        b = $urandom_range(0, a / 8);
                        steps = ((lim > a) ? lim - a : 0) + a / 32 + $urandom_range(1, 4);
                    end else begin
                        case ($urandom_range(0, 2))
                            0: a = $urandom_range(1, 15);
                            1: a = $urandom_range(16, 127);
                            default: a = $urandom_range(128, AXIS_MAX);
                        endcase
                        lo = (a / 4 > 1) ? a / 4 : 1;
                        hi = (4 * a > AXIS_MAX) ? AXIS_MAX : 4 * a;
                        b = $urandom_range(lo, hi);
                        lim = live_regs[CFG_Y_LIMIT];
                        steps = $urandom_range(lim + 1, 4 * lim + 4);
                    end
                    if ($urandom_range(0, 7) == 0)
                        steps = $urandom_range(1, 4);
                    draw_curve(a, b, steps);
                end
                if ($urandom_range(0, 9) == 0)
                    sender_pause();
            end
        end

        sender_pause();
        $display("Covered %0d input beats over %0d register settings, %0d points checked.",
                 beats, settings, points);
        $display("%0d curves reached their last point, %0d crossed into the flat region.",
                 curve_ends, region2_entries);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/mhr_pkg.sv
src/midpoint_hyperbola_rasterizer_core.sv
sim/midpoint_hyperbola_rasterizer_core_checker.sv
sim/midpoint_hyperbola_rasterizer_core_tb.sv
